// ===== design/rqps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqps_pkg
// Shared types and constants of the run queue priority set: sizes, request
// and status codes, sequencer states, stored entry and compare result.
// ----------------------------------------------------------------------------
package rqps_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
	localparam int KEY_W       = 64;
	localparam int ID_W        = 31;
	localparam int ENTRY_W     = KEY_W + ID_W;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_POP    = 2'd2,
		REQ_PEEK   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_NONE  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} entry_t;

	typedef struct packed {
		logic eq;
		logic less;
	} cmp_res_t;

endpackage

`default_nettype wire

// ===== design/run_queue_priority_set.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// run_queue_priority_set
// Ordered run queue of task entries (runtime, id) with insert, remove,
// pop smallest and peek smallest requests.
// ----------------------------------------------------------------------------
// usage
//   a request transaction is taken at a clock edge with start high and busy
//   low; req_type, run_time and task_id are sampled at that edge
//   each request gives one result: done is high for one cycle with status,
//   out_run_time, out_task_id and entry_count valid in that cycle
//   the receiver cannot hold results off, and none is needed: only one
//   request is in flight at a time
// timing
//   every request sweeps all MAX_ENTRIES slots of the entry RAM, one read a
//   cycle through the single read port, with one shared comparator
//   the result is registered in state S_DONE after the sweep; busy drops in
//   the cycle done is high, so a new request can be taken with start high
//   while done is high
// reset
//   arst_n low empties the queue at once: all slot valid bits and the entry
//   count clear; the entry RAM is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module run_queue_priority_set (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    req_type,
	input  wire logic [rqps_pkg::KEY_W-1:0]    run_time,
	input  wire logic [rqps_pkg::ID_W-1:0]     task_id,
	output logic                               done,
	output logic      [1:0]                    status,
	output logic      [rqps_pkg::KEY_W-1:0]    out_run_time,
	output logic      [rqps_pkg::ID_W-1:0]     out_task_id,
	output logic      [rqps_pkg::COUNT_W-1:0]  entry_count
);

	import rqps_pkg::*;

	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(MAX_ENTRIES - 1);
	localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(MAX_ENTRIES);
	localparam logic [COUNT_W-1:0] CNT_ONE   = COUNT_W'(1);

	state_t                 state_q;
	state_t                 state_d;

	req_t                   req_q;
	logic [IDX_W-1:0]       addr_q;
	logic                   last_q;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   found_q;
	logic [IDX_W-1:0]       best_idx_q;
	entry_t                 best_q;

	logic [MAX_ENTRIES-1:0] valid_q;
	logic [COUNT_W-1:0]     cnt_q;

	logic                   done_q;
	status_t                status_q;
	logic [KEY_W-1:0]       out_key_q;
	logic [ID_W-1:0]        out_id_q;
	logic [COUNT_W-1:0]     count_q;

	logic [ENTRY_W-1:0]     rd_data;
	entry_t                 rd_entry;
	cmp_res_t               cmp_res;
	logic                   slot_v;
	logic                   scan_hit;
	logic                   ram_we;
	logic                   accept;
	logic                   has_room;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign rd_entry = entry_t'(rd_data);
	assign slot_v   = valid_q[idx_s1];
	assign has_room = (cnt_q < FULL_CNT) && found_q;
	assign ram_we   = (state_q == S_DONE) && (req_q == REQ_INSERT) && has_room;

	rqps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (best_idx_q),
		.wdata (best_q),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	rqps_cmp u_cmp (
		.a   (rd_data),
		.b   (best_q),
		.res (cmp_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (vld_s1 && (idx_s1 == LAST_IDX)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// slot selection for the current request
	always_comb begin
		scan_hit = 1'b0;
		unique case (req_q)
			REQ_INSERT: scan_hit = !slot_v && !found_q;
			REQ_REMOVE: scan_hit = slot_v && cmp_res.eq && !found_q;
			REQ_POP, REQ_PEEK: scan_hit = slot_v && (!found_q || cmp_res.less);
		endcase
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			last_q  <= 1'b0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else if (accept) begin
			addr_q  <= '0;
			last_q  <= 1'b0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else if (state_q == S_SCAN) begin
			if (!last_q) begin
				vld_s1 <= 1'b1;
				addr_q <= addr_q + IDX_W'(1);
				if (addr_q == LAST_IDX) begin
					last_q <= 1'b1;
				end
			end else begin
				vld_s1 <= 1'b0;
			end
			if (vld_s1 && scan_hit) begin
				found_q <= 1'b1;
			end
		end
	end

	// request and best entry
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_t'(req_type);
			best_q  <= '{key: run_time, id: task_id};
		end else if (state_q == S_SCAN) begin
			if (!last_q) begin
				idx_s1 <= addr_q;
			end
			if (vld_s1 && scan_hit) begin
				best_idx_q <= idx_s1;
				if ((req_q == REQ_POP) || (req_q == REQ_PEEK)) begin
					best_q <= rd_entry;
				end
			end
		end
	end

	// queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
		end else if (state_q == S_DONE) begin
			unique case (req_q)
				REQ_INSERT: begin
					if (has_room) begin
						valid_q[best_idx_q] <= 1'b1;
						cnt_q               <= cnt_q + CNT_ONE;
					end
				end
				REQ_REMOVE, REQ_POP: begin
					if (found_q) begin
						valid_q[best_idx_q] <= 1'b0;
						if (cnt_q != '0) begin
							cnt_q <= cnt_q - CNT_ONE;
						end
					end
				end
				REQ_PEEK: begin
				end
			endcase
		end
	end

	// result transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == S_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			out_key_q <= '0;
			out_id_q  <= '0;
			status_q  <= STAT_OK;
			count_q   <= cnt_q;
			unique case (req_q)
				REQ_INSERT: begin
					if (has_room) begin
						count_q <= cnt_q + CNT_ONE;
					end else begin
						status_q <= STAT_FULL;
					end
				end
				REQ_REMOVE: begin
					if (found_q) begin
						if (cnt_q != '0) begin
							count_q <= cnt_q - CNT_ONE;
						end
					end else begin
						status_q <= STAT_NONE;
					end
				end
				REQ_POP, REQ_PEEK: begin
					if (found_q) begin
						out_key_q <= best_q.key;
						out_id_q  <= best_q.id;
						if ((req_q == REQ_POP) && (cnt_q != '0)) begin
							count_q <= cnt_q - CNT_ONE;
						end
					end else begin
						status_q <= STAT_NONE;
					end
				end
			endcase
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_run_time = out_key_q;
	assign out_task_id  = out_id_q;
	assign entry_count  = count_q;

endmodule

`default_nettype wire

// ===== design/rqps_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqps_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module rqps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/rqps_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqps_cmp
// Shared entry comparator: exact match and ordering by runtime, then by
// the lower task id.
// ----------------------------------------------------------------------------
module rqps_cmp (
	input  wire logic              [rqps_pkg::ENTRY_W-1:0] a,
	input  wire logic              [rqps_pkg::ENTRY_W-1:0] b,
	output rqps_pkg::cmp_res_t     res
);

	import rqps_pkg::*;

	entry_t ea;
	entry_t eb;
	logic   key_eq;

	assign ea       = entry_t'(a);
	assign eb       = entry_t'(b);
	assign key_eq   = (ea.key == eb.key);
	assign res.eq   = key_eq && (ea.id == eb.id);
	assign res.less = (ea.key < eb.key) || (key_eq && (ea.id < eb.id));

endmodule

`default_nettype wire
